>>> src/tcprx_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcprx_pkg
// shared item types, codes and constants of the tcp receive segment engine
// ----------------------------------------------------------------------------
package tcprx_pkg;

  // operation codes of an input item
  localparam logic OP_FRAME_BYTE = 1'b0;
  localparam logic OP_READ       = 1'b1;

  // result kinds
  localparam logic KIND_VERDICT = 1'b0;
  localparam logic KIND_READ    = 1'b1;

  // verdict codes
  localparam logic [1:0] VERDICT_DROPPED    = 2'd0;
  localparam logic [1:0] VERDICT_NO_PAYLOAD = 2'd1;
  localparam logic [1:0] VERDICT_IN_ORDER   = 2'd2;
  localparam logic [1:0] VERDICT_OUT_ORDER  = 2'd3;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_PORT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_APP_OWNED   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_SCALE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_RCV   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_START_UNACK = 3'd4;

  // frame layout
  localparam logic [16:0] ETH_BYTES   = 17'd14;
  localparam logic [16:0] MIN_FRAME   = 17'd54;
  localparam logic [5:0]  MIN_HDR     = 6'd20;
  localparam logic [3:0]  MAX_SCALE   = 4'd14;
  localparam int unsigned ACK_FLAG    = 4;

  // ports whose payload is swallowed when no application owns the socket
  localparam logic [15:0] PORT_HTTP  = 16'd80;
  localparam logic [15:0] PORT_SSH   = 16'd22;
  localparam logic [15:0] PORT_HTTPS = 16'd443;

  typedef struct packed {
    logic       operation;
    logic [7:0] data_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [1:0]  verdict;
    logic        send_ack;
    logic [11:0] accepted_len;
    logic        ack_advanced;
    logic [31:0] next_expected_seq;
    logic [31:0] acked_up_to;
    logic [29:0] send_window;
    logic [8:0]  rx_fill;
    logic [7:0]  read_byte;
    logic        read_valid;
  } out_item_t;

  // back part status towards the front part
  typedef struct packed {
    logic [2:0] q_count;
  } back_status_t;

  localparam int unsigned QUEUE_DEPTH = 4;

endpackage : tcprx_pkg
`default_nettype wire

>>> src/tcp_receive_segment_engine.sv
// Takes one frame byte or one buffer read per cycle while not stalled; a frame's
// verdict and a read's data pass through the parse stage register, the result
// queue and the output register. A four-entry queue decouples the parser from
// the consumer, so input stalls only once the consumer has held off long enough
// to fill it. The receive buffer is one memory with one write and one read
// port.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcp_receive_segment_engine
// in-order tcp receive path: header capture, frame checks, receive buffer
// ----------------------------------------------------------------------------
module tcp_receive_segment_engine #(
  parameter int unsigned RX_DEPTH  = 256,
  parameter int unsigned MAX_FRAME = 2048
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_stall,
  input  tcprx_pkg::in_item_t            in_data,
  output logic                           out_valid,
  input  wire                            out_stall,
  output tcprx_pkg::out_item_t           out_data,
  input  wire                            cfg_we,
  input  wire [tcprx_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire [31:0]                     cfg_wdata
);
  import tcprx_pkg::*;

  back_status_t back_st;
  logic         push_valid;
  out_item_t    push_item;

  // parser and connection state
  tcprx_front #(.RX_DEPTH(RX_DEPTH), .MAX_FRAME(MAX_FRAME)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .back_st(back_st), .push_valid(push_valid), .push_item(push_item)
  );

  // result queue and output
  tcprx_back u_back (
    .clk(clk), .rst_n(rst_n),
    .push_valid(push_valid), .push_item(push_item), .back_st(back_st),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

endmodule : tcp_receive_segment_engine
`default_nettype wire

>>> src/tcprx_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcprx_front
// parses frame bytes, keeps connection and buffer state, produces result items
// ----------------------------------------------------------------------------
module tcprx_front #(
  parameter int unsigned RX_DEPTH  = 256,
  parameter int unsigned MAX_FRAME = 2048
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_valid,
  output logic                       in_stall,
  input  tcprx_pkg::in_item_t        in_data,
  input  wire                        cfg_we,
  input  wire [tcprx_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire [31:0]                 cfg_wdata,
  input  tcprx_pkg::back_status_t    back_st,
  output logic                       push_valid,
  output tcprx_pkg::out_item_t       push_item
);
  import tcprx_pkg::*;

  localparam int unsigned AW = $clog2(RX_DEPTH);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned PW = $clog2(MAX_FRAME + 1);

  // configuration
  logic [15:0] port_r;
  logic        own_r;
  logic [3:0]  scale_r;
  // frame capture
  logic [PW-1:0] pos_r, pos_nxt;
  logic [5:0]  ih_r, ih_nxt, th_r, th_nxt;
  logic [15:0] tot_r, tot_nxt, win_r, win_nxt;
  logic [31:0] seq_r, seq_nxt, ack_r, ack_nxt;
  logic [7:0]  flg_r, flg_nxt;
  logic        bad_r, bad_nxt;
  logic [CW-1:0] tent_r, tent_nxt;
  // connection and buffer
  logic [31:0] rnxt_r, rnxt_nxt, una_r, una_nxt;
  logic [29:0] pwin_r, pwin_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  // result stage
  logic        s1_v_r, s1_rd_r;
  out_item_t   s1_item_r, item_nxt;
  logic [7:0]  rd_q_r;
  logic [7:0]  mem [RX_DEPTH];

  logic        accept, is_read, pop, over, in_tcp, wr_en, fin, mal, adv, bridged, inorder;
  logic [16:0] p17, t17, n17;
  logic [CW:0] used;
  logic [AW+1:0] slot_sum;
  logic [AW-1:0] slot;
  logic [31:0] dlt;
  logic [15:0] pay, acc16, tent16;
  logic [3:0]  sc;
  logic [7:0]  b;

  assign in_stall = ({1'b0, back_st.q_count} + {3'b000, s1_v_r}) >= 4'(QUEUE_DEPTH);
  assign accept   = in_valid && !in_stall;
  assign is_read  = (in_data.operation == OP_READ);
  assign b        = in_data.data_byte;

  // byte capture and tentative store write
  always_comb begin
    p17      = 17'(pos_r);
    over     = p17 >= 17'(MAX_FRAME);
    pos_nxt  = over ? pos_r : pos_r + 1'b1;
    bad_nxt  = bad_r | over;
    ih_nxt   = (!over && p17 == ETH_BYTES) ? {b[3:0], 2'b00} : ih_r;
    tot_nxt  = tot_r;
    if (!over && p17 == ETH_BYTES + 17'd2) begin
      tot_nxt = {b, 8'h00};
    end else if (!over && p17 == ETH_BYTES + 17'd3) begin
      tot_nxt = {tot_r[15:8], tot_r[7:0] | b};
    end
    in_tcp  = !over && p17 >= ETH_BYTES + 17'(ih_nxt) && p17 >= ETH_BYTES + 17'd1;
    t17     = p17 - ETH_BYTES - 17'(ih_nxt);
    seq_nxt = seq_r;
    ack_nxt = ack_r;
    th_nxt  = th_r;
    flg_nxt = flg_r;
    win_nxt = win_r;
    if (in_tcp) begin
      if (t17 >= 17'd4 && t17 < 17'd8) begin
        seq_nxt = {seq_r[23:0], b};
      end else if (t17 >= 17'd8 && t17 < 17'd12) begin
        ack_nxt = {ack_r[23:0], b};
      end else if (t17 == 17'd12) begin
        th_nxt = {b[7:4], 2'b00};
      end else if (t17 == 17'd13) begin
        flg_nxt = b;
      end else if (t17 == 17'd14 || t17 == 17'd15) begin
        win_nxt = {win_r[7:0], b};
      end
    end
    used   = {1'b0, cnt_r} + {1'b0, tent_r};
    wr_en  = accept && !is_read && !over && ih_nxt >= MIN_HDR && th_nxt >= MIN_HDR &&
             p17 >= ETH_BYTES + 17'(ih_nxt) + 17'(th_nxt) &&
             p17 < ETH_BYTES + 17'(tot_nxt) && used < (CW+1)'(RX_DEPTH);
    slot_sum = (AW+2)'(head_r) + (AW+2)'(used);
    slot     = (slot_sum >= (AW+2)'(RX_DEPTH)) ? AW'(slot_sum - (AW+2)'(RX_DEPTH))
                                               : AW'(slot_sum);
    tent_nxt = tent_r + CW'(wr_en);
  end

  // frame end checks and connection update
  always_comb begin
    n17 = 17'(pos_nxt);
    mal = bad_nxt || n17 < MIN_FRAME || ih_nxt < MIN_HDR ||
          n17 < ETH_BYTES + 17'(ih_nxt) + 17'(MIN_HDR) || th_nxt < MIN_HDR ||
          n17 < ETH_BYTES + 17'(ih_nxt) + 17'(th_nxt) ||
          17'(tot_nxt) < 17'(ih_nxt) + 17'(th_nxt) || ETH_BYTES + 17'(tot_nxt) > n17;
    sc      = (scale_r > MAX_SCALE) ? MAX_SCALE : scale_r;
    dlt     = ack_nxt - una_r;
    adv     = flg_nxt[ACK_FLAG] && dlt != 32'd0 && !dlt[31];
    pay     = tot_nxt - 16'(ih_nxt) - 16'(th_nxt);
    bridged = (port_r == PORT_HTTP || port_r == PORT_SSH || port_r == PORT_HTTPS) && !own_r;
    inorder = seq_nxt == rnxt_r;
    tent16  = 16'(tent_nxt);
    acc16   = bridged ? pay : ((tent16 < pay) ? tent16 : pay);
    fin     = accept && !is_read && in_data.last;
    pop     = accept && is_read && cnt_r != '0;

    rnxt_nxt = rnxt_r;
    una_nxt  = una_r;
    pwin_nxt = pwin_r;
    cnt_nxt  = cnt_r;
    head_nxt = head_r;
    item_nxt = '0;
    if (pop) begin
      head_nxt = (head_r == AW'(RX_DEPTH - 1)) ? '0 : head_r + 1'b1;
      cnt_nxt  = cnt_r - 1'b1;
    end
    if (fin && !mal) begin
      pwin_nxt = 30'(win_nxt) << sc;
      if (adv) begin
        una_nxt = ack_nxt;
      end
      if (pay != 16'd0 && inorder) begin
        rnxt_nxt = seq_nxt + 32'(acc16);
        if (!bridged) begin
          cnt_nxt = cnt_r + CW'(acc16);
        end
      end
    end
    // result item
    item_nxt.kind              = is_read ? KIND_READ : KIND_VERDICT;
    item_nxt.next_expected_seq = rnxt_nxt;
    item_nxt.acked_up_to       = una_nxt;
    item_nxt.send_window       = pwin_nxt;
    item_nxt.rx_fill           = 9'(cnt_nxt);
    item_nxt.read_valid        = pop;
    if (!is_read && !mal) begin
      item_nxt.ack_advanced = adv;
      if (pay == 16'd0) begin
        item_nxt.verdict = VERDICT_NO_PAYLOAD;
      end else begin
        item_nxt.send_ack = 1'b1;
        if (inorder) begin
          item_nxt.verdict      = VERDICT_IN_ORDER;
          item_nxt.accepted_len = acc16[11:0];
        end else begin
          item_nxt.verdict = VERDICT_OUT_ORDER;
        end
      end
    end else if (!is_read) begin
      item_nxt.verdict = VERDICT_DROPPED;
    end
  end

  // receive buffer
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[slot] <= b;
    end
    if (pop) begin
      rd_q_r <= mem[head_r];
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      port_r <= '0; own_r <= 1'b0; scale_r <= '0;
      pos_r <= '0; ih_r <= '0; th_r <= '0; tot_r <= '0; win_r <= '0;
      seq_r <= '0; ack_r <= '0; flg_r <= '0; bad_r <= 1'b0; tent_r <= '0;
      rnxt_r <= '0; una_r <= '0; pwin_r <= '0; head_r <= '0; cnt_r <= '0;
      s1_v_r <= 1'b0; s1_rd_r <= 1'b0;
    end else begin
      s1_v_r <= accept && (is_read || in_data.last);
      if (accept) begin
        s1_item_r <= item_nxt;
        s1_rd_r   <= pop;
        rnxt_r    <= rnxt_nxt;
        una_r     <= una_nxt;
        pwin_r    <= pwin_nxt;
        cnt_r     <= cnt_nxt;
        head_r    <= head_nxt;
      end
      if (accept && !is_read) begin
        if (in_data.last) begin
          pos_r <= '0; ih_r <= '0; th_r <= '0; tot_r <= '0; win_r <= '0;
          seq_r <= '0; ack_r <= '0; flg_r <= '0; bad_r <= 1'b0; tent_r <= '0;
        end else begin
          pos_r <= pos_nxt; ih_r <= ih_nxt; th_r <= th_nxt; tot_r <= tot_nxt;
          win_r <= win_nxt; seq_r <= seq_nxt; ack_r <= ack_nxt; flg_r <= flg_nxt;
          bad_r <= bad_nxt; tent_r <= tent_nxt;
        end
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_LOCAL_PORT:  port_r  <= cfg_wdata[15:0];
          CFG_APP_OWNED:   own_r   <= cfg_wdata[0];
          CFG_WIN_SCALE:   scale_r <= cfg_wdata[3:0];
          CFG_START_RCV:   rnxt_r  <= cfg_wdata;
          CFG_START_UNACK: una_r   <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // merge the popped byte into the read item
  always_comb begin
    push_valid = s1_v_r;
    push_item  = s1_item_r;
    push_item.read_byte = s1_rd_r ? rd_q_r : 8'h00;
  end

endmodule : tcprx_front
`default_nettype wire

>>> src/tcprx_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcprx_back
// result queue and output register towards the consumer
// ----------------------------------------------------------------------------
module tcprx_back (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     push_valid,
  input  tcprx_pkg::out_item_t    push_item,
  output tcprx_pkg::back_status_t back_st,
  output logic                    out_valid,
  input  wire                     out_stall,
  output tcprx_pkg::out_item_t    out_data
);
  import tcprx_pkg::*;

  localparam int unsigned QW = $clog2(QUEUE_DEPTH);

  out_item_t   q_mem [QUEUE_DEPTH];
  logic [QW-1:0] wp_r, rp_r;
  logic [QW:0] cnt_r;
  logic        out_v_r, pop;
  out_item_t   out_r;

  assign pop = (cnt_r != '0) && (!out_v_r || !out_stall);
  assign back_st.q_count = 3'(cnt_r);
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // queue storage
  always_ff @(posedge clk) begin
    if (push_valid) begin
      q_mem[wp_r] <= push_item;
    end
    if (pop) begin
      out_r <= q_mem[rp_r];
    end
  end

  // pointers and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0; out_v_r <= 1'b0;
    end else begin
      if (push_valid) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (QW+1)'(push_valid) - (QW+1)'(pop);
      if (pop) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

endmodule : tcprx_back
`default_nettype wire

>>> src/tcprx_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcprx_chk
// port level checks of the tcp receive segment engine
// ----------------------------------------------------------------------------
module tcprx_chk (
  input wire                            clk,
  input wire                            rst_n,
  input wire                            in_valid,
  input wire                            in_stall,
  input tcprx_pkg::in_item_t            in_data,
  input wire                            out_valid,
  input wire                            out_stall,
  input tcprx_pkg::out_item_t           out_data
);
  import tcprx_pkg::*;

  // a stalled input item stays offered
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("input item changed while stalled");

  // a stalled result item stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  // a verdict item never carries read data
  a_verdict_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_VERDICT |->
      !out_data.read_valid && out_data.read_byte == 8'h00)
    else $error("verdict item carries read data");

  // a dropped frame accepts nothing and asks for no ack
  a_drop_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_VERDICT && out_data.verdict == VERDICT_DROPPED |->
      !out_data.send_ack && out_data.accepted_len == 12'd0 && !out_data.ack_advanced)
    else $error("dropped frame reported activity");

  // an empty read returns zero and no frame fields
  a_empty_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_READ && !out_data.read_valid |->
      out_data.read_byte == 8'h00 && out_data.verdict == VERDICT_DROPPED)
    else $error("empty read returned data");

endmodule : tcprx_chk

bind tcp_receive_segment_engine tcprx_chk u_chk (.*);
`default_nettype wire

>>> verif/tcp_receive_segment_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_receive_segment_engine_tb
// drives ethernet/ipv4/tcp frames byte by byte with buffer reads mixed in,
// predicts every verdict and read item in a scoreboard and checks each field
// ----------------------------------------------------------------------------
module tcp_receive_segment_engine_tb;
  import tcprx_pkg::*;

  localparam int unsigned RX_DEPTH  = 256;
  localparam int unsigned MAX_FRAME = 2048;

  // expected-result tracker with its own copy of the receive path state
  class rx_segment_scoreboard;
    logic [15:0] local_port;
    logic        app_claimed;
    logic [3:0]  win_scale;
    int unsigned pos, ip_hdr, tcp_hdr, ip_len;
    logic [31:0] seg_seq, seg_ack;
    logic [7:0]  seg_flags;
    logic [15:0] seg_win;
    bit          bad;
    logic [31:0] receive_next, unacked_oldest, peer_window;
    logic [7:0]  store [RX_DEPTH];
    int unsigned head, count, tentative;
    out_item_t   due_q[$];
    int          errors;

    function new();
      local_port = '0; app_claimed = 1'b0; win_scale = '0;
      receive_next = '0; unacked_oldest = '0; peer_window = '0;
      head = 0; count = 0; errors = 0;
      foreach (store[i]) store[i] = '0;
      clear_frame();
    endfunction

    function void clear_frame();
      pos = 0; ip_hdr = 0; tcp_hdr = 0; ip_len = 0;
      seg_seq = '0; seg_ack = '0; seg_flags = '0; seg_win = '0;
      bad = 0; tentative = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
      case (idx)
        CFG_LOCAL_PORT:  local_port = val[15:0];
        CFG_APP_OWNED:   app_claimed = val[0];
        CFG_WIN_SCALE:   win_scale = val[3:0];
        CFG_START_RCV:   receive_next = val;
        CFG_START_UNACK: unacked_oldest = val;
        default: ;
      endcase
    endfunction

    function void add_due(logic kind, logic [1:0] verdict, logic ack, int unsigned acc,
                          logic adv, logic [7:0] rb, logic rv);
      out_item_t r;
      r.kind = kind; r.verdict = verdict; r.send_ack = ack;
      r.accepted_len = acc[11:0]; r.ack_advanced = adv;
      r.next_expected_seq = receive_next; r.acked_up_to = unacked_oldest;
      r.send_window = peer_window[29:0]; r.rx_fill = count[8:0];
      r.read_byte = rb; r.read_valid = rv;
      due_q.push_back(r);
    endfunction

    function void take_byte(logic [7:0] b);
      int unsigned p, t;
      if (pos >= MAX_FRAME) begin
        bad = 1;
        return;
      end
      p = pos;
      pos = p + 1;
      if (p == ETH_BYTES) ip_hdr = int'(b[3:0]) * 4;
      else if (p == ETH_BYTES + 2) ip_len = {16'h0, b, 8'h00};
      else if (p == ETH_BYTES + 3) ip_len = ip_len | {24'h0, b};
      // tcp header fields, located behind the ip header
      if (p >= ETH_BYTES + ip_hdr && p >= ETH_BYTES + 1) begin
        t = p - ETH_BYTES - ip_hdr;
        if (t >= 4 && t < 8) seg_seq = {seg_seq[23:0], b};
        else if (t >= 8 && t < 12) seg_ack = {seg_ack[23:0], b};
        else if (t == 12) tcp_hdr = int'(b[7:4]) * 4;
        else if (t == 13) seg_flags = b;
        else if (t == 14 || t == 15) seg_win = {seg_win[7:0], b};
      end
      // tentative payload write behind the committed bytes
      if (ip_hdr >= MIN_HDR && tcp_hdr >= MIN_HDR && p >= ETH_BYTES + ip_hdr + tcp_hdr &&
          p < ETH_BYTES + ip_len && count + tentative < RX_DEPTH) begin
        store[(head + count + tentative) % RX_DEPTH] = b;
        tentative++;
      end
    endfunction

    function void finish_frame();
      int unsigned eth, mh, pay, acc;
      logic [31:0] d;
      logic [3:0]  sc;
      logic        adv;
      logic [1:0]  verdict;
      eth = ETH_BYTES; mh = MIN_HDR;
      acc = 0; adv = 1'b0;
      if (bad || pos < eth + 2 * mh || ip_hdr < mh || pos < eth + ip_hdr + mh ||
          tcp_hdr < mh || pos < eth + ip_hdr + tcp_hdr || ip_len < ip_hdr + tcp_hdr ||
          eth + ip_len > pos) begin
        add_due(KIND_VERDICT, VERDICT_DROPPED, 1'b0, 0, 1'b0, 8'h00, 1'b0);
        return;
      end
      sc = (win_scale > MAX_SCALE) ? MAX_SCALE : win_scale;
      peer_window = {16'h0, seg_win} << sc;
      if (seg_flags[ACK_FLAG]) begin
        d = seg_ack - unacked_oldest;
        if (d != 0 && !d[31]) begin
          unacked_oldest = seg_ack;
          adv = 1'b1;
        end
      end
      pay = ip_len - ip_hdr - tcp_hdr;
      if (pay == 0) begin
        verdict = VERDICT_NO_PAYLOAD;
      end else if (seg_seq == receive_next) begin
        verdict = VERDICT_IN_ORDER;
        // bridged ports swallow the payload when nobody owns the socket
        if ((local_port == PORT_HTTP || local_port == PORT_SSH || local_port == PORT_HTTPS)
            && !app_claimed) begin
          acc = pay;
        end else begin
          acc = (tentative < pay) ? tentative : pay;
          count += acc;
        end
        receive_next = seg_seq + acc;
      end else begin
        verdict = VERDICT_OUT_ORDER;
      end
      add_due(KIND_VERDICT, verdict, pay != 0, acc, adv, 8'h00, 1'b0);
    endfunction

    function void note_item(in_item_t it);
      logic [7:0] rb;
      logic       rv;
      if (it.operation == OP_READ) begin
        rb = '0;
        rv = 1'b0;
        if (count > 0) begin
          rb = store[head];
          head = (head + 1) % RX_DEPTH;
          count--;
          rv = 1'b1;
        end
        add_due(KIND_READ, VERDICT_DROPPED, 1'b0, 0, 1'b0, rb, rv);
        return;
      end
      take_byte(it.data_byte);
      if (it.last) begin
        finish_frame();
        clear_frame();
      end
    endfunction

    function void cmp(string name, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
        $error("%s: expected %0h, got %0h", name, e, a);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (due_q.size() == 0) begin
        $error("result item with nothing expected: %p", got);
        errors++;
        return;
      end
      e = due_q.pop_front();
      cmp("kind", e.kind, got.kind);
      cmp("verdict", e.verdict, got.verdict);
      cmp("send_ack", e.send_ack, got.send_ack);
      cmp("accepted_len", e.accepted_len, got.accepted_len);
      cmp("ack_advanced", e.ack_advanced, got.ack_advanced);
      cmp("next_expected_seq", e.next_expected_seq, got.next_expected_seq);
      cmp("acked_up_to", e.acked_up_to, got.acked_up_to);
      cmp("send_window", e.send_window, got.send_window);
      cmp("rx_fill", e.rx_fill, got.rx_fill);
      cmp("read_byte", e.read_byte, got.read_byte);
      cmp("read_valid", e.read_valid, got.read_valid);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  rx_segment_scoreboard sb = new();
  int idle_pct = 0;
  int stall_pct = 0;
  int n_items = 0;

  tcp_receive_segment_engine #(.RX_DEPTH(RX_DEPTH), .MAX_FRAME(MAX_FRAME)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  // receiver back-pressure
  always @(posedge clk) begin
    out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
  end

  // result items are taken mid-cycle, where stall and data are settled
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // one item onto the input channel, with random idle cycles ahead of it
  task automatic push_item(input in_item_t it);
    bit taken;
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    taken = 0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
    sb.note_item(it);
    n_items++;
  endtask

  task automatic read_byte_item();
    in_item_t it;
    it.operation = OP_READ;
    it.data_byte = 8'($urandom);
    it.last = 1'($urandom);
    push_item(it);
  endtask

  // all results in, then a few idle cycles
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.due_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  function automatic void put_byte(ref logic [7:0] f[$], input int k, input logic [7:0] v);
    if (k < f.size()) f[k] = v;
  endfunction

  // frame image: ethernet, ipv4 header, tcp header, payload, trailing bytes
  function automatic void make_frame(ref logic [7:0] f[$], input int ihl, input int doff,
                                     input int plen, input int trail, input int tot_adj,
                                     input logic [31:0] seq, input logic [31:0] ackn,
                                     input logic [7:0] flags, input logic [15:0] win);
    int tot, th;
    logic [3:0] hi;
    f.delete();
    repeat (14 + ihl * 4 + doff * 4 + plen + trail) f.push_back(8'($urandom));
    tot = ihl * 4 + doff * 4 + plen + tot_adj;
    th = 14 + ihl * 4;
    hi = 4'($urandom);
    put_byte(f, 14, {hi, ihl[3:0]});
    put_byte(f, 16, tot[15:8]);
    put_byte(f, 17, tot[7:0]);
    for (int i = 0; i < 4; i++) begin
      put_byte(f, th + 4 + i, seq[31 - 8 * i -: 8]);
      put_byte(f, th + 8 + i, ackn[31 - 8 * i -: 8]);
    end
    hi = 4'($urandom);
    put_byte(f, th + 12, {doff[3:0], hi});
    put_byte(f, th + 13, flags);
    put_byte(f, th + 14, win[15:8]);
    put_byte(f, th + 15, win[7:0]);
  endfunction

  task automatic send_frame(ref logic [7:0] f[$], input int read_pct);
    in_item_t it;
    for (int i = 0; i < f.size(); i++) begin
      if ($urandom_range(99) < read_pct) read_byte_item();
      it.operation = OP_FRAME_BYTE;
      it.data_byte = f[i];
      it.last = (i == f.size() - 1);
      push_item(it);
    end
  endtask

  // mostly well-formed frames near the live pointers, some broken ones
  task automatic random_frame();
    logic [7:0] f[$];
    int ihl, doff, plen, trail, tot_adj, r, cut;
    logic [31:0] seq, ackn;
    logic [7:0] flags;
    ihl = ($urandom_range(3) == 0) ? $urandom_range(5, 15) : 5;
    doff = ($urandom_range(3) == 0) ? $urandom_range(5, 15) : 5;
    r = $urandom_range(19);
    plen = (r < 4) ? 0 : (r == 19) ? $urandom_range(100, 300) : $urandom_range(1, 30);
    trail = ($urandom_range(4) == 0) ? $urandom_range(1, 6) : 0;
    tot_adj = 0;
    r = $urandom_range(19);
    seq = (r < 15) ? sb.receive_next : (r < 18) ? sb.receive_next + $urandom_range(1, 8) - 4
          : $urandom;
    r = $urandom_range(9);
    ackn = (r < 3) ? sb.unacked_oldest + $urandom_range(1, 5000) : (r < 5) ? sb.unacked_oldest
           : (r < 7) ? sb.unacked_oldest - $urandom_range(1, 100)
           : (r == 7) ? sb.unacked_oldest + 32'h8000_0000 : $urandom;
    flags = 8'($urandom);
    flags[ACK_FLAG] = ($urandom_range(3) != 0);
    cut = 0;
    if ($urandom_range(99) < 15) begin
      case ($urandom_range(5))
        0: ihl = $urandom_range(0, 4);
        1: doff = $urandom_range(0, 4);
        2: tot_adj = trail + $urandom_range(1, 20);
        3: tot_adj = -plen - $urandom_range(1, 20);
        4: cut = $urandom_range(1, 40);
        default: begin
          ihl = 0; doff = 0; plen = 0; trail = $urandom_range(0, 60);
        end
      endcase
    end
    make_frame(f, ihl, doff, plen, trail, tot_adj, seq, ackn, flags, 16'($urandom));
    while (cut > 0 && f.size() > 1) begin
      void'(f.pop_back());
      cut--;
    end
    send_frame(f, (sb.count > 200) ? 60 : 12);
    // occasional burst of reads, sometimes well past empty
    if ($urandom_range(5) == 0) repeat ($urandom_range(1, 40)) read_byte_item();
  endtask

  task automatic set_config(input logic [15:0] port, input logic app, input logic [3:0] sc,
                            input logic [31:0] rcv, input logic [31:0] una);
    logic [31:0] junk;
    drain();
    junk = $urandom;
    write_reg(CFG_LOCAL_PORT, {junk[31:16], port});
    junk = $urandom;
    write_reg(CFG_APP_OWNED, {junk[31:1], app});
    junk = $urandom;
    write_reg(CFG_WIN_SCALE, {junk[31:4], sc});
    write_reg(CFG_START_RCV, rcv);
    write_reg(CFG_START_UNACK, una);
  endtask

  initial begin
    logic [7:0] f[$];
    int goal;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty read, minimal frame, in-order with mid-frame read,
    // out of order with trailing bytes, out of order, short junk, then reads
    set_config(PORT_HTTP, 1'b1, 4'd0, 32'hFFFF_FFFE, 32'h0000_0010);
    read_byte_item();
    make_frame(f, 5, 5, 0, 0, 0, 32'h1234_5678, 32'h0000_0020, 8'h10, 16'hFFFF);
    send_frame(f, 0);
    make_frame(f, 5, 5, 3, 0, 0, 32'hFFFF_FFFE, 32'h0000_0000, 8'hFF, 16'h0001);
    send_frame(f, 5);
    make_frame(f, 5, 5, 4, 2, 0, 32'h0, 32'h8000_0020, 8'h10, 16'h0);
    send_frame(f, 0);
    make_frame(f, 5, 5, 4, 0, 0, 32'h7, 32'h0, 8'h00, 16'h8000);
    send_frame(f, 0);
    f.delete();
    repeat (10) f.push_back(8'($urandom));
    send_frame(f, 0);
    repeat (6) read_byte_item();

    // random phases, each with its own settings and idling pattern
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin set_config(PORT_HTTP, 1'b0, 4'd0, 32'h0, 32'h0);
                 idle_pct = 0; stall_pct = 0; end
        1: begin set_config(PORT_HTTPS, 1'b1, MAX_SCALE, 32'hFFFF_FFF0, 32'h7FFF_FFF0);
                 idle_pct = 56; stall_pct = 0; end
        2: begin set_config(PORT_SSH, 1'b0, 4'd15, $urandom, $urandom);
                 idle_pct = 0; stall_pct = 56; end
        3: begin set_config(16'hFFFF, 1'b1, 4'd7, $urandom, 32'hFFFF_FFFF);
                 idle_pct = 14; stall_pct = 14; end
        4: begin set_config(PORT_HTTPS, 1'b0, 4'($urandom), $urandom, $urandom);
                 idle_pct = 56; stall_pct = 56; end
        default: begin set_config(16'h0, 1'b1, 4'($urandom), 32'h7FFF_FFFF, 32'h0);
                 idle_pct = 0; stall_pct = 0; end
      endcase
      goal = n_items + 220;
      while (n_items < goal) random_frame();
    end

    drain();
    repeat (12) @(posedge clk);
    if (sb.errors == 0 && sb.due_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // guard against a hung handshake
  initial begin
    #4ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> filelist.f
src/tcprx_pkg.sv
src/tcprx_front.sv
src/tcprx_back.sv
src/tcp_receive_segment_engine.sv
src/tcprx_chk.sv
verif/tcp_receive_segment_engine_tb.sv
